// File: rtl/mtep_pkg.sv
// Shared types, codes and helpers of the MIDI track event parser.
package mtep_pkg;

    typedef enum logic [3:0] {
        PH_DELTA      = 4'd0,
        PH_STATUS     = 4'd1,
        PH_DATA1      = 4'd2,
        PH_DATA2      = 4'd3,
        PH_META_TYPE  = 4'd4,
        PH_META_LEN   = 4'd5,
        PH_META_SKIP  = 4'd6,
        PH_SYSEX_LEN  = 4'd7,
        PH_SYSEX_SKIP = 4'd8
    } t_phase;

    typedef enum logic [1:0] {
        KIND_CHANNEL = 2'd0,
        KIND_META    = 2'd1,
        KIND_SYSEX   = 2'd2,
        KIND_ERROR   = 2'd3
    } t_kind;

    typedef enum logic [2:0] {
        ERR_NONE         = 3'd0,
        ERR_STRAY_EOX    = 3'd1,
        ERR_UNKNOWN_META = 3'd2,
        ERR_BAD_STATUS   = 3'd3,
        ERR_TRUNCATED    = 3'd4
    } t_err;

    localparam logic [7:0] STATUS_META  = 8'hFF;
    localparam logic [7:0] STATUS_SYSEX = 8'hF0;
    localparam logic [7:0] STATUS_EOX   = 8'hF7;
    localparam logic [3:0] HI_PROGRAM   = 4'hC;
    localparam logic [3:0] HI_PRESSURE  = 4'hD;
    localparam logic [1:0] VLQ_MAX      = 2'd3;

    typedef struct packed {
        t_phase      phase;
        logic [15:0] length_accum;
        logic [1:0]  length_bytes_seen;
        logic [15:0] delta_hold;
        logic [7:0]  running_status;
        logic        status_valid;
        logic [7:0]  first_data_hold;
        logic [7:0]  meta_type_hold;
        logic [15:0] skip_remaining;
        logic        halted;
    } t_state;

    localparam t_state STATE_RESET = '{
        phase:             PH_DELTA,
        length_accum:      16'd0,
        length_bytes_seen: 2'd0,
        delta_hold:        16'd0,
        running_status:    8'd0,
        status_valid:      1'b0,
        first_data_hold:   8'd0,
        meta_type_hold:    8'd0,
        skip_remaining:    16'd0,
        halted:            1'b0
    };

    typedef struct packed {
        t_kind       kind;
        logic [15:0] delta_time;
        logic [7:0]  status_byte;
        logic [7:0]  data_one;
        logic [7:0]  data_two;
        logic [1:0]  data_count;
        logic [7:0]  meta_kind;
        logic [15:0] payload_length;
        t_err        error_code;
        logic        track_end;
    } t_result;

    function automatic logic meta_known(input logic [7:0] mtype);
        logic known;
        unique case (mtype)
            8'h03, 8'h05, 8'h06, 8'h20, 8'h21,
            8'h2F, 8'h51, 8'h54, 8'h58, 8'h59: known = 1'b1;
            default:                           known = 1'b0;
        endcase
        return known;
    endfunction

endpackage

// File: rtl/midi_track_event_parser.sv
// Top level: input register, parser core and result register of the track parser.
// A byte waits in the input register; its result is registered as the byte leaves it.
// Throughput: one byte per cycle unless a held result waits; each byte decodes in one core step.
// The result register frees itself in the cycle it is taken, so bytes flow while results drain.
// Reset (synchronous, active low) empties both registers and returns the parser
// to waiting for a delta time with no running status.
module midi_track_event_parser
    import mtep_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // track_byte
    input  logic [0:0]  s_axis_tuser,   // first_byte
    input  logic        s_axis_tlast,   // last_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // delta_time, status_byte, data_one, data_two, data_count, meta_kind,
    // payload_length, error_code, then zero fill
    output logic [71:0] m_axis_tdata,
    output logic [1:0]  m_axis_tuser,   // item_kind
    output logic        m_axis_tlast    // track_end
);

    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_first;
    logic       r_in_last;
    logic       r_out_valid;
    t_result    r_out;
    logic       w_fire;
    logic       w_res_valid;
    t_result    w_res;

    assign w_fire        = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || w_fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tvalid && s_axis_tready) begin
            r_in_valid <= 1'b1;
        end else if (w_fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_byte  <= s_axis_tdata;
            r_in_first <= s_axis_tuser[0];
            r_in_last  <= s_axis_tlast;
        end
    end

    mtep_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (w_fire),
        .i_byte      (r_in_byte),
        .i_first     (r_in_first),
        .i_last      (r_in_last),
        .o_res_valid (w_res_valid),
        .o_res       (w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_fire) begin
            r_out_valid <= w_res_valid;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_out <= w_res;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out.kind;
    assign m_axis_tlast  = r_out.track_end;
    assign m_axis_tdata  = {3'b000, r_out.error_code, r_out.payload_length, r_out.meta_kind,
                            r_out.data_count, r_out.data_two, r_out.data_one,
                            r_out.status_byte, r_out.delta_time};

    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !m_axis_tvalid)
        else $error("result register not empty after reset");

    a_err_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> ((r_out.kind == KIND_ERROR) == (r_out.error_code != ERR_NONE)))
        else $error("error code does not match item kind");

    a_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && r_out.kind != KIND_CHANNEL |-> r_out.data_count == 2'd0)
        else $error("data count set on a non-channel item");

    a_stall_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> r_in_valid && r_out_valid && !m_axis_tready)
        else $error("input stalled without a blocked result");

endmodule

// File: rtl/mtep_core.sv
// Parser state registers and the per-byte decode step.
module mtep_core
    import mtep_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_en,
    input  logic [7:0] i_byte,
    input  logic       i_first,
    input  logic       i_last,
    output logic       o_res_valid,
    output t_result    o_res
);

    t_state r_state;
    t_state n_state;

    always_comb begin
        t_state      cur;
        logic [15:0] v_acc;
        logic [1:0]  v_seen;
        logic        v_done;
        logic        e_valid;
        t_kind       e_kind;
        logic [7:0]  e_status;
        logic [7:0]  e_d1;
        logic [7:0]  e_d2;
        logic [1:0]  e_cnt;
        logic [7:0]  e_meta;
        logic [15:0] e_plen;
        t_err        e_err;
        logic [15:0] e_delta;

        cur = i_first ? STATE_RESET : r_state;
        n_state = cur;
        v_acc  = {cur.length_accum[8:0], i_byte[6:0]};
        v_seen = cur.length_bytes_seen + 2'd1;
        v_done = !i_byte[7] || (v_seen == VLQ_MAX);
        e_valid  = 1'b0;
        e_kind   = KIND_CHANNEL;
        e_status = 8'd0;
        e_d1     = 8'd0;
        e_d2     = 8'd0;
        e_cnt    = 2'd0;
        e_meta   = 8'd0;
        e_plen   = 16'd0;
        e_err    = ERR_NONE;

        if (!cur.halted) begin
            unique case (cur.phase)
                PH_DELTA: begin
                    n_state.length_accum      = v_acc;
                    n_state.length_bytes_seen = v_seen;
                    if (v_done) begin
                        n_state.delta_hold = v_acc;
                        n_state.phase      = PH_STATUS;
                    end
                end
                PH_STATUS: begin
                    if (i_byte[7]) begin
                        if (i_byte == STATUS_META) begin
                            n_state.status_valid = 1'b0;
                            n_state.phase        = PH_META_TYPE;
                        end else if (i_byte == STATUS_SYSEX) begin
                            n_state.status_valid      = 1'b0;
                            n_state.length_accum      = 16'd0;
                            n_state.length_bytes_seen = 2'd0;
                            n_state.phase             = PH_SYSEX_LEN;
                        end else if (i_byte == STATUS_EOX) begin
                            e_valid  = 1'b1;
                            e_kind   = KIND_ERROR;
                            e_status = i_byte;
                            e_err    = ERR_STRAY_EOX;
                        end else if (i_byte[7:4] == 4'hF) begin
                            e_valid  = 1'b1;
                            e_kind   = KIND_ERROR;
                            e_status = i_byte;
                            e_err    = ERR_BAD_STATUS;
                        end else begin
                            n_state.running_status = i_byte;
                            n_state.status_valid   = 1'b1;
                            n_state.phase          = PH_DATA1;
                        end
                    end else if (!cur.status_valid) begin
                        e_valid  = 1'b1;
                        e_kind   = KIND_ERROR;
                        e_status = i_byte;
                        e_err    = ERR_BAD_STATUS;
                    end else begin
                        // Running status: this byte is already the first data byte.
                        n_state.first_data_hold = i_byte;
                        if (cur.running_status[7:4] == HI_PROGRAM ||
                            cur.running_status[7:4] == HI_PRESSURE) begin
                            e_valid  = 1'b1;
                            e_status = cur.running_status;
                            e_d1     = i_byte;
                            e_cnt    = 2'd1;
                            n_state.phase             = PH_DELTA;
                            n_state.length_accum      = 16'd0;
                            n_state.length_bytes_seen = 2'd0;
                        end else begin
                            n_state.phase = PH_DATA2;
                        end
                    end
                end
                PH_DATA1: begin
                    n_state.first_data_hold = i_byte;
                    if (cur.running_status[7:4] == HI_PROGRAM ||
                        cur.running_status[7:4] == HI_PRESSURE) begin
                        e_valid  = 1'b1;
                        e_status = cur.running_status;
                        e_d1     = i_byte;
                        e_cnt    = 2'd1;
                        n_state.phase             = PH_DELTA;
                        n_state.length_accum      = 16'd0;
                        n_state.length_bytes_seen = 2'd0;
                    end else begin
                        n_state.phase = PH_DATA2;
                    end
                end
                PH_DATA2: begin
                    e_valid  = 1'b1;
                    e_status = cur.running_status;
                    e_d1     = cur.first_data_hold;
                    e_d2     = i_byte;
                    e_cnt    = 2'd2;
                    n_state.phase             = PH_DELTA;
                    n_state.length_accum      = 16'd0;
                    n_state.length_bytes_seen = 2'd0;
                end
                PH_META_TYPE: begin
                    n_state.meta_type_hold    = i_byte;
                    n_state.length_accum      = 16'd0;
                    n_state.length_bytes_seen = 2'd0;
                    n_state.phase             = PH_META_LEN;
                end
                PH_META_LEN, PH_SYSEX_LEN: begin
                    n_state.length_accum      = v_acc;
                    n_state.length_bytes_seen = v_seen;
                    if (v_done) begin
                        n_state.skip_remaining = v_acc;
                        if (v_acc == 16'd0) begin
                            e_valid = 1'b1;
                        end else begin
                            n_state.phase = (cur.phase == PH_META_LEN) ? PH_META_SKIP
                                                                       : PH_SYSEX_SKIP;
                        end
                    end
                end
                PH_META_SKIP, PH_SYSEX_SKIP: begin
                    n_state.skip_remaining = cur.skip_remaining - 16'd1;
                    if (n_state.skip_remaining == 16'd0) begin
                        e_valid = 1'b1;
                    end
                end
                default: begin
                    n_state.phase             = PH_DELTA;
                    n_state.length_accum      = 16'd0;
                    n_state.length_bytes_seen = 2'd0;
                end
            endcase

            // A finished meta or sysex payload reports here and returns to delta time.
            if (e_valid && (cur.phase == PH_META_LEN || cur.phase == PH_META_SKIP)) begin
                e_status = STATUS_META;
                e_meta   = cur.meta_type_hold;
                e_plen   = n_state.length_accum;
                if (meta_known(cur.meta_type_hold)) begin
                    e_kind = KIND_META;
                end else begin
                    e_kind = KIND_ERROR;
                    e_err  = ERR_UNKNOWN_META;
                end
                n_state.phase             = PH_DELTA;
                n_state.length_accum      = 16'd0;
                n_state.length_bytes_seen = 2'd0;
            end else if (e_valid &&
                         (cur.phase == PH_SYSEX_LEN || cur.phase == PH_SYSEX_SKIP)) begin
                e_kind   = KIND_SYSEX;
                e_status = STATUS_SYSEX;
                e_plen   = n_state.length_accum;
                n_state.phase             = PH_DELTA;
                n_state.length_accum      = 16'd0;
                n_state.length_bytes_seen = 2'd0;
            end

            if (e_valid && e_kind == KIND_ERROR) begin
                n_state.halted = 1'b1;
            end

            if (i_last) begin
                if (!e_valid) begin
                    // The chunk ended inside an event.
                    e_valid = 1'b1;
                    e_kind  = KIND_ERROR;
                    e_err   = ERR_TRUNCATED;
                    if (n_state.phase == PH_DATA1 || n_state.phase == PH_DATA2) begin
                        e_status = n_state.running_status;
                    end else if (n_state.phase == PH_META_TYPE ||
                                 n_state.phase == PH_META_LEN ||
                                 n_state.phase == PH_META_SKIP) begin
                        e_status = STATUS_META;
                    end else if (n_state.phase == PH_SYSEX_LEN ||
                                 n_state.phase == PH_SYSEX_SKIP) begin
                        e_status = STATUS_SYSEX;
                    end
                    if (n_state.phase == PH_META_LEN || n_state.phase == PH_META_SKIP) begin
                        e_meta = n_state.meta_type_hold;
                    end
                    if (n_state.phase == PH_DELTA) begin
                        n_state.delta_hold = 16'd0;
                    end
                    n_state.halted = 1'b1;
                end
            end
        end

        e_delta = n_state.delta_hold;
        if (!cur.halted && i_last && e_valid && !n_state.halted) begin
            n_state = STATE_RESET;
        end

        o_res_valid          = e_valid;
        o_res.kind           = e_kind;
        o_res.delta_time     = e_delta;
        o_res.status_byte    = e_status;
        o_res.data_one       = e_d1;
        o_res.data_two       = e_d2;
        o_res.data_count     = e_cnt;
        o_res.meta_kind      = e_meta;
        o_res.payload_length = e_plen;
        o_res.error_code     = e_err;
        o_res.track_end      = i_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= STATE_RESET;
        end else if (i_en) begin
            r_state <= n_state;
        end
    end

endmodule
